FILE: design/adaptive_commit_interval_unit_assert.svh
// Assertion macros shared by the adaptive commit interval design.
`ifndef ADAPTIVE_COMMIT_INTERVAL_UNIT_ASSERT_SVH
`define ADAPTIVE_COMMIT_INTERVAL_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define ACU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acu assertion failed");
`define ACU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acu assertion failed");
`else
`define ACU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ACU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/acu_pkg.sv
// Package with widths, reset values and register indexes of the commit interval unit.
`timescale 1ns / 1ps
package acu_pkg;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 64;
    localparam int INTERVAL_W = 16;
    localparam int THRESH_W   = 20;
    localparam int QUIET_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int STEP_W     = $clog2(COUNT_W);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ENABLE         = 3'd0;
    localparam t_cfg_idx CFG_START_INTERVAL = 3'd1;
    localparam t_cfg_idx CFG_RATE_THRESHOLD = 3'd2;
    localparam t_cfg_idx CFG_MAX_INTERVAL   = 3'd3;
    localparam t_cfg_idx CFG_MIN_INTERVAL   = 3'd4;
    localparam t_cfg_idx CFG_QUIET_LIMIT    = 3'd5;

    localparam logic [INTERVAL_W-1:0] RST_START_INTERVAL = 16'd30;
    localparam logic [THRESH_W-1:0]   RST_RATE_THRESHOLD = 20'd500;
    localparam logic [INTERVAL_W-1:0] RST_MAX_INTERVAL   = 16'd900;
    localparam logic [INTERVAL_W-1:0] RST_MIN_INTERVAL   = 16'd30;
    localparam logic [QUIET_W-1:0]    RST_QUIET_LIMIT    = 16'd60;
    localparam logic [QUIET_W-1:0]    QUIET_MAX          = 16'hFFFF;
    localparam logic [STEP_W-1:0]     LAST_STEP          = 6'd63;
endpackage

FILE: design/acu_tick_if.sv
// Channel interface that carries timer ticks into the unit.
`timescale 1ns / 1ps
interface acu_tick_if import acu_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  now_seconds;
    logic [COUNT_W-1:0] modify_count;

    modport source (output valid, output now_seconds, output modify_count, input ready);
    modport sink (input valid, input now_seconds, input modify_count, output ready);
endinterface

FILE: design/acu_result_if.sv
// Channel interface that carries one result per tick out of the unit.
`timescale 1ns / 1ps
interface acu_result_if import acu_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [INTERVAL_W-1:0] interval;
    logic                  evaluated;
    logic                  busy_rate;

    modport source (output valid, output interval, output evaluated, output busy_rate,
                    input ready);
    modport sink (input valid, input interval, input evaluated, input busy_rate,
                  output ready);
endinterface

FILE: design/acu_cfg_if.sv
// Register write channel interface of the unit.
`timescale 1ns / 1ps
interface acu_cfg_if import acu_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/adaptive_commit_interval_unit.sv
// Adaptive commit interval unit: measures the modification rate per tick and adjusts the interval.
// An evaluated tick passes from its transfer through 64 steps of a one-bit-per-cycle
// restoring divider that forms the rate from the counter delta and the elapsed seconds,
// then an update step, and then the load of the output register, which waits until that
// register is free. A tick that is not evaluated goes from its transfer straight to the
// output register load. One tick is in progress at a time; a finished result waits in the
// output register while the next tick is taken. Register writes are taken in every cycle.
`timescale 1ns / 1ps
`include "adaptive_commit_interval_unit_assert.svh"
module adaptive_commit_interval_unit import acu_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    acu_tick_if.sink      i_tick,
    acu_cfg_if.sink       i_cfg,
    acu_result_if.source  o_result
);
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_UPDATE, S_DONE} t_state;

    t_state                r_state;
    logic                  r_enable;
    logic [THRESH_W-1:0]   r_threshold;
    logic [INTERVAL_W-1:0] r_max;
    logic [INTERVAL_W-1:0] r_min;
    logic [QUIET_W-1:0]    r_quiet_limit;
    logic [INTERVAL_W-1:0] r_cur;
    logic [TIME_W-1:0]     r_last_time;
    logic [COUNT_W-1:0]    r_last_count;
    logic [QUIET_W-1:0]    r_quiet;

    logic [TIME_W-1:0]     r_now;
    logic [COUNT_W-1:0]    r_count;
    logic [COUNT_W-1:0]    r_quo;
    logic [TIME_W-1:0]     r_rem;
    logic [TIME_W-1:0]     r_div;
    logic [STEP_W-1:0]     r_step;
    logic                  r_eval;
    logic                  r_busy;

    logic                  r_out_valid;
    logic [INTERVAL_W-1:0] r_out_interval;
    logic                  r_out_eval;
    logic                  r_out_busy;

    logic                  tick_fire;
    logic                  eval_now;
    logic [TIME_W:0]       rem_shift;
    logic                  quo_bit;
    logic [TIME_W-1:0]     n_rem;
    logic                  n_busy;
    logic [QUIET_W-1:0]    n_quiet;
    logic [INTERVAL_W+1:0] grown;
    logic [INTERVAL_W-1:0] halved;
    logic [INTERVAL_W-1:0] n_cur;
    logic                  out_free;

    assign i_tick.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign tick_fire    = i_tick.valid && i_tick.ready;
    assign eval_now     = r_enable && (r_cur != '0) && (i_tick.now_seconds > r_last_time);
    assign out_free     = !r_out_valid || o_result.ready;

    assign rem_shift = {r_rem, r_quo[COUNT_W-1]};
    assign quo_bit   = (rem_shift >= {1'b0, r_div});
    assign n_rem     = quo_bit ? TIME_W'(rem_shift - {1'b0, r_div}) : rem_shift[TIME_W-1:0];

    assign n_busy = (r_quo > COUNT_W'(r_threshold));
    assign grown  = {r_cur, 2'b00};
    assign halved = r_cur >> 1;

    always_comb begin
        n_quiet = r_quiet;
        n_cur   = r_cur;
        if (n_busy) begin
            n_quiet = '0;
            n_cur   = (grown < {2'b00, r_max}) ? grown[INTERVAL_W-1:0] : r_max;
        end else begin
            if (r_quiet < QUIET_MAX) begin
                n_quiet = r_quiet + 1'b1;
            end
            if (n_quiet > r_quiet_limit) begin
                n_cur = (halved > r_min) ? halved : r_min;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_enable      <= 1'b1;
            r_threshold   <= RST_RATE_THRESHOLD;
            r_max         <= RST_MAX_INTERVAL;
            r_min         <= RST_MIN_INTERVAL;
            r_quiet_limit <= RST_QUIET_LIMIT;
            r_cur         <= RST_START_INTERVAL;
            r_last_time   <= '0;
            r_last_count  <= '0;
            r_quiet       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_ENABLE:         r_enable      <= i_cfg.data[0];
                    CFG_START_INTERVAL: r_cur         <= i_cfg.data[INTERVAL_W-1:0];
                    CFG_RATE_THRESHOLD: r_threshold   <= i_cfg.data[THRESH_W-1:0];
                    CFG_MAX_INTERVAL:   r_max         <= i_cfg.data[INTERVAL_W-1:0];
                    CFG_MIN_INTERVAL:   r_min         <= i_cfg.data[INTERVAL_W-1:0];
                    CFG_QUIET_LIMIT:    r_quiet_limit <= i_cfg.data[QUIET_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (tick_fire) begin
                        r_now   <= i_tick.now_seconds;
                        r_count <= i_tick.modify_count;
                        r_quo   <= i_tick.modify_count - r_last_count;
                        r_div   <= i_tick.now_seconds - r_last_time;
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_eval  <= eval_now;
                        r_busy  <= 1'b0;
                        r_state <= eval_now ? S_DIV : S_DONE;
                    end
                end
                S_DIV: begin
                    r_rem  <= n_rem;
                    r_quo  <= {r_quo[COUNT_W-2:0], quo_bit};
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_busy       <= n_busy;
                    r_quiet      <= n_quiet;
                    r_cur        <= n_cur;
                    r_last_time  <= r_now;
                    r_last_count <= r_count;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_interval <= r_cur;
                        r_out_eval     <= r_eval;
                        r_out_busy     <= r_busy;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.interval  = r_out_interval;
    assign o_result.evaluated = r_out_eval;
    assign o_result.busy_rate = r_out_busy;

    `ACU_ASSERT_SAME(a_busy_needs_eval, i_clk, i_rst_n, r_out_valid && r_out_busy, r_out_eval)
    `ACU_ASSERT_NEXT(a_eval_starts_div, i_clk, i_rst_n, tick_fire && eval_now, r_state == S_DIV)
    `ACU_ASSERT_SAME(a_div_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_div != '0)
    `ACU_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n, r_state == S_DIV && r_step == LAST_STEP,
                     r_state == S_UPDATE)
endmodule
